@@ design/state_space_matrix_recurrence_defines.svh @@
// Assertion macros for the state-space recursion block.
`ifndef STATE_SPACE_MATRIX_RECURRENCE_DEFINES_SVH
`define STATE_SPACE_MATRIX_RECURRENCE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SSMR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssmr: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define SSMR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssmr: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define SSMR_ASSERT_RESET(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ssmr: reset check failed");

`endif

@@ design/ssmr_pkg.sv @@
`default_nettype none
package ssmr_pkg;

  localparam int LANES     = 4;
  localparam int VAL_W     = 24;
  localparam int ROW_W     = 2;
  localparam int OP_W      = 2;
  localparam int ORDER_DEF = 4;
  localparam int FRAC_DEF  = 16;

  localparam logic [OP_W-1:0] OP_LOAD_ROW   = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_STATE = 2'd1;
  localparam logic [OP_W-1:0] OP_STEP       = 2'd2;

  typedef logic signed [VAL_W-1:0] val_t;

  localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [ROW_W-1:0] row;
    val_t             v0;
    val_t             v1;
    val_t             v2;
    val_t             v3;
  } cmd_t;

  typedef struct packed {
    val_t h0;
    val_t h1;
    val_t h2;
    val_t h3;
    logic saturated;
  } res_t;

endpackage
`default_nettype wire

@@ design/ssmr_stream_if.sv @@
`default_nettype none
interface ssmr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ design/ssmr_coef_bank.sv @@
`default_nettype none
module ssmr_coef_bank #(
  parameter int ACTIVE = ssmr_pkg::LANES
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [ssmr_pkg::ROW_W-1:0]  row,
  input  wire ssmr_pkg::val_t              wdata [ACTIVE],
  output ssmr_pkg::val_t                   coef  [ACTIVE][ACTIVE]
);

  // no reset: contents are undefined until a row is loaded
  ssmr_pkg::val_t mem [ACTIVE][ACTIVE];

  always_ff @(posedge clk) begin
    for (int r = 0; r < ACTIVE; r++) begin
      if (we && row == ssmr_pkg::ROW_W'(r)) begin
        mem[r] <= wdata;
      end
    end
  end

  assign coef = mem;

endmodule
`default_nettype wire

@@ design/ssmr_mac_row.sv @@
`default_nettype none
module ssmr_mac_row #(
  parameter int ACTIVE        = ssmr_pkg::LANES,
  parameter int FRACTION_BITS = ssmr_pkg::FRAC_DEF
) (
  input  wire ssmr_pkg::val_t coef  [ACTIVE],
  input  wire ssmr_pkg::val_t state [ACTIVE],
  input  wire ssmr_pkg::val_t x,
  output ssmr_pkg::val_t      h,
  output logic                sat
);

  localparam int PROD_W = 2 * ssmr_pkg::VAL_W;
  // x plus up to four scaled products: three guard bits
  localparam int SUM_W  = PROD_W - FRACTION_BITS + 3;

  logic signed [PROD_W-1:0] prod [ACTIVE];
  logic signed [SUM_W-1:0]  acc;

  always_comb begin
    acc = SUM_W'(x);
    for (int j = 0; j < ACTIVE; j++) begin
      prod[j] = PROD_W'(coef[j]) * PROD_W'(state[j]);
      // arithmetic shift rounds each product toward minus infinity
      acc = acc + SUM_W'(prod[j] >>> FRACTION_BITS);
    end
  end

  always_comb begin
    if (acc > SUM_W'(ssmr_pkg::VAL_MAX)) begin
      h   = ssmr_pkg::VAL_MAX;
      sat = 1'b1;
    end else if (acc < SUM_W'(ssmr_pkg::VAL_MIN)) begin
      h   = ssmr_pkg::VAL_MIN;
      sat = 1'b1;
    end else begin
      h   = ssmr_pkg::val_t'(acc);
      sat = 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ design/state_space_matrix_recurrence.sv @@
`default_nettype none
// Order-N state-space recursion h[t] = A*h[t-1] + x[t] in signed Q7.16 (24-bit) fixed
// point. Each item on cmd is one of: load a row of A (op 0, ignored when row is at or
// above the active order), load the initial state (op 1), or step with an input vector
// (op 2), which emits one item on res with the new state and a flag set when any element
// was clamped to the 24-bit range. Op 3 is dropped. The active order is min(ORDER, 4);
// result lanes above it read zero. Load A before the first step: unloaded coefficients
// give undefined results. Throughput is one item per clock, any mix of ops, while res is
// not stalled; a step's result passes the input register, then the result register.
// That rate is set by the state feedback loop, which holds no register inside it: state
// registers -> ACTIVE*ACTIVE parallel 24x24 multipliers -> per-row add and saturate ->
// state registers. An input register and a result register separate the two channels,
// so cmd keeps flowing while a result waits, until a step meets a full result register.
module state_space_matrix_recurrence #(
  parameter int ORDER         = ssmr_pkg::ORDER_DEF,
  parameter int FRACTION_BITS = ssmr_pkg::FRAC_DEF
) (
  input wire logic       clk,
  input wire logic       rst,
  ssmr_stream_if.sink    cmd,
  ssmr_stream_if.source  res
);

  localparam int LANES  = ssmr_pkg::LANES;
  localparam int ACTIVE = (ORDER < LANES) ? ORDER : LANES;

  // input register
  logic            in_valid;
  logic            in_valid_next;
  ssmr_pkg::cmd_t  in_item;

  // result register
  logic            res_valid;
  logic            res_valid_next;
  ssmr_pkg::res_t  res_data;
  ssmr_pkg::res_t  res_data_next;

  // state vector, cleared by reset
  ssmr_pkg::val_t  state [ACTIVE];

  ssmr_pkg::val_t  vin   [LANES];
  ssmr_pkg::val_t  wdata [ACTIVE];
  ssmr_pkg::val_t  coef  [ACTIVE][ACTIVE];
  ssmr_pkg::val_t  hnew  [ACTIVE];
  logic            row_sat [ACTIVE];
  ssmr_pkg::val_t  hlane [LANES];

  logic accept;
  logic advance;
  logic is_step;
  logic is_load_row;
  logic is_load_state;
  logic coef_we;
  logic any_sat;

  assign vin[0] = in_item.v0;
  assign vin[1] = in_item.v1;
  assign vin[2] = in_item.v2;
  assign vin[3] = in_item.v3;

  assign is_step       = in_item.op == ssmr_pkg::OP_STEP;
  assign is_load_row   = in_item.op == ssmr_pkg::OP_LOAD_ROW;
  assign is_load_state = in_item.op == ssmr_pkg::OP_LOAD_STATE;

  // a held item moves on unless it is a step blocked by a full result register
  assign advance = in_valid && (!is_step || !res_valid || res.ready);
  assign accept  = cmd.valid && cmd.ready;

  assign cmd.ready = !in_valid || advance;

  always_comb begin
    in_valid_next = in_valid;
    if (accept) begin
      in_valid_next = 1'b1;
    end else if (advance) begin
      in_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= in_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item <= cmd.payload;
    end
  end

  // coefficient writes: drop rows at or above the active order
  assign coef_we = advance && is_load_row &&
                   ({1'b0, in_item.row} < (ssmr_pkg::ROW_W + 1)'(ACTIVE));

  for (genvar i = 0; i < ACTIVE; i++) begin : g_wdata
    assign wdata[i] = vin[i];
  end

  ssmr_coef_bank #(
    .ACTIVE (ACTIVE)
  ) u_coef_bank (
    .clk   (clk),
    .we    (coef_we),
    .row   (in_item.row),
    .wdata (wdata),
    .coef  (coef)
  );

  // one multiply-accumulate row per active state element
  for (genvar i = 0; i < ACTIVE; i++) begin : g_row
    ssmr_mac_row #(
      .ACTIVE        (ACTIVE),
      .FRACTION_BITS (FRACTION_BITS)
    ) u_mac_row (
      .coef  (coef[i]),
      .state (state),
      .x     (vin[i]),
      .h     (hnew[i]),
      .sat   (row_sat[i])
    );
  end

  always_comb begin
    any_sat = 1'b0;
    for (int i = 0; i < ACTIVE; i++) begin
      any_sat = any_sat | row_sat[i];
    end
  end

  // lanes beyond the active order read zero
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    if (i < ACTIVE) begin : g_on
      assign hlane[i] = hnew[i];
    end else begin : g_off
      assign hlane[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ACTIVE; i++) begin
        state[i] <= '0;
      end
    end else if (advance && is_load_state) begin
      for (int i = 0; i < ACTIVE; i++) begin
        state[i] <= vin[i];
      end
    end else if (advance && is_step) begin
      state <= hnew;
    end
  end

  always_comb begin
    res_valid_next = res_valid;
    res_data_next  = res_data;
    if (advance && is_step) begin
      res_valid_next          = 1'b1;
      res_data_next.h0        = hlane[0];
      res_data_next.h1        = hlane[1];
      res_data_next.h2        = hlane[2];
      res_data_next.h3        = hlane[3];
      res_data_next.saturated = any_sat;
    end else if (res.ready) begin
      res_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    res_data <= res_data_next;
  end

  assign res.valid   = res_valid;
  assign res.payload = res_data;

endmodule
`default_nettype wire

@@ design/ssmr_checker.sv @@
`default_nettype none
`include "state_space_matrix_recurrence_defines.svh"
module ssmr_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           cmd_ready,
  input wire logic           res_valid,
  input wire logic           res_ready,
  input wire ssmr_pkg::res_t res_payload
);

  // reset empties both registers
  `SSMR_ASSERT_RESET(a_reset_empty, clk, rst, !res_valid && cmd_ready)

  // cmd only backs up behind a stalled result
  `SSMR_ASSERT_NOW(a_stall_cause, clk, rst, !cmd_ready, res_valid && !res_ready)

  `SSMR_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid)

  `SSMR_ASSERT_NEXT(a_res_stable, clk, rst, res_valid && !res_ready, $stable(res_payload))

endmodule

bind state_space_matrix_recurrence ssmr_checker u_ssmr_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_ready   (cmd.ready),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_payload (res.payload)
);
`default_nettype wire

@@ sim/state_space_matrix_recurrence_test.sv @@
`default_nettype none
module state_space_matrix_recurrence_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef ssmr_pkg::val_t val_t;
  typedef ssmr_pkg::cmd_t cmd_t;
  typedef ssmr_pkg::res_t res_t;

  localparam int LANES = ssmr_pkg::LANES;

  // Block configuration under test: the default order and fraction width.
  localparam int ORDER  = ssmr_pkg::ORDER_DEF;
  localparam int FRAC   = ssmr_pkg::FRAC_DEF;
  localparam int ACTIVE = (ORDER < LANES) ? ORDER : LANES;

  // The op code the block drops without a result.
  localparam logic [ssmr_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  // Handy Q7.16 values: one, one half, one quarter.
  localparam val_t ONE     = 24'sd65536;
  localparam val_t HALF    = 24'sd32768;
  localparam val_t QUARTER = 24'sd16384;

  // Random part stops once this many loads and steps have been accepted.
  localparam int WORK_ITEMS = 2000;

  // Cap on printed mismatch lines; every mismatch is still counted.
  localparam int MAX_SHOWN = 50;

  logic clk = 1'b0;
  logic rst;

  ssmr_stream_if #(.payload_t(cmd_t)) cmd_ch ();
  ssmr_stream_if #(.payload_t(res_t)) res_ch ();

  state_space_matrix_recurrence #(
    .ORDER(ORDER),
    .FRACTION_BITS(FRAC)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  // Tracks the coefficient matrix and the state vector as the block should hold
  // them, and keeps the new states that steps have yet to deliver, oldest first.
  class state_tracker;
    val_t coef[LANES][LANES];
    val_t state_h[LANES];
    res_t next_states[$];
    int   failures;
    int   shown;

    function new();
      foreach (coef[i, j]) coef[i][j] = '0;
      foreach (state_h[i]) state_h[i] = '0;
      failures = 0;
      shown = 0;
    endfunction

    task flag_mismatch(input string msg);
      failures++;
      if (shown < MAX_SHOWN) $display("%0t ns: mismatch: %s", $realtime, msg);
      shown++;
    endtask

    function int pending();
      return next_states.size();
    endfunction

    // Apply one accepted item; a step queues the state it must produce.
    function void accept_cmd(input cmd_t c);
      val_t    v[LANES];
      val_t    nxt[LANES];
      longint  acc;
      logic    clamped;
      res_t    e;
      v = '{c.v0, c.v1, c.v2, c.v3};
      case (c.op)
        ssmr_pkg::OP_LOAD_ROW: begin
          if (c.row < ACTIVE)
            for (int j = 0; j < ACTIVE; j++) coef[c.row][j] = v[j];
        end
        ssmr_pkg::OP_LOAD_STATE: begin
          for (int i = 0; i < ACTIVE; i++) state_h[i] = v[i];
        end
        ssmr_pkg::OP_STEP: begin
          clamped = 1'b0;
          foreach (nxt[i]) nxt[i] = '0;
          for (int i = 0; i < ACTIVE; i++) begin
            acc = longint'(v[i]);
            // Each product is floored by the arithmetic shift; the sum stays exact.
            for (int j = 0; j < ACTIVE; j++)
              acc += (longint'(coef[i][j]) * longint'(state_h[j])) >>> FRAC;
            if (acc > longint'(ssmr_pkg::VAL_MAX)) begin
              acc = longint'(ssmr_pkg::VAL_MAX);
              clamped = 1'b1;
            end
            if (acc < longint'(ssmr_pkg::VAL_MIN)) begin
              acc = longint'(ssmr_pkg::VAL_MIN);
              clamped = 1'b1;
            end
            nxt[i] = val_t'(acc);
          end
          state_h = nxt;
          e.h0 = nxt[0];
          e.h1 = nxt[1];
          e.h2 = nxt[2];
          e.h3 = nxt[3];
          e.saturated = clamped;
          next_states.push_back(e);
        end
        default: ;
      endcase
    endfunction

    task check_state(input res_t got);
      res_t e;
      val_t got_h[LANES];
      val_t exp_h[LANES];
      if (next_states.size() == 0) begin
        flag_mismatch("result with no step outstanding");
        return;
      end
      e = next_states.pop_front();
      got_h = '{got.h0, got.h1, got.h2, got.h3};
      exp_h = '{e.h0, e.h1, e.h2, e.h3};
      for (int i = 0; i < LANES; i++)
        if (got_h[i] !== exp_h[i])
          flag_mismatch($sformatf("h%0d got %0d expected %0d", i, got_h[i], exp_h[i]));
      if (got.saturated !== e.saturated)
        flag_mismatch($sformatf("saturated got %b expected %b", got.saturated, e.saturated));
    endtask
  endclass

  state_tracker tracker = new();

  int unsigned burst_left = 0;
  int          work_items = 0;

  // Free-running clock, 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: check each accepted item, then pick next cycle's ready.
  // Ready follows one of several stall modes, each picked at random, so stalls
  // land on every phase of the pipeline, with free-flowing stretches in between.
  typedef enum logic [1:0] {RX_FLOW, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_t;
  rx_mode_t    rx_mode = RX_FLOW;
  int unsigned rx_cycle = 0;

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) tracker.check_state(res_ch.payload);
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 97 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
      case (rx_mode)
        RX_FLOW:   res_ch.ready <= 1'b1;
        RX_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: res_ch.ready <= ($urandom_range(0, 5) == 0);
        default:   res_ch.ready <= (rx_cycle[2:1] != 2'b00);
      endcase
    end
  end

  // Full-range value, biased toward the corners of the 24-bit range.
  function automatic val_t any_val();
    case ($urandom_range(0, 15))
      0:       return ssmr_pkg::VAL_MAX;
      1:       return ssmr_pkg::VAL_MIN;
      2:       return val_t'(-1);
      default: return val_t'($urandom());
    endcase
  endfunction

  // Small signed value in [-lim, lim].
  function automatic val_t near_val(input int lim);
    return val_t'(int'($urandom_range(0, 2 * lim)) - lim);
  endfunction

  // Drive one item and wait for its acceptance. Bursts of random length run
  // back to back; between bursts drop valid for a random gap, or skip the gap.
  task automatic push_cmd(input cmd_t c);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    cmd_ch.valid <= 1'b1;
    cmd_ch.payload <= c;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    tracker.accept_cmd(c);
  endtask

  task automatic send_cmd(input logic [ssmr_pkg::OP_W-1:0] op,
                          input logic [ssmr_pkg::ROW_W-1:0] row,
                          input val_t a, input val_t b, input val_t c, input val_t d);
    cmd_t item;
    item.op = op;
    item.row = row;
    item.v0 = a;
    item.v1 = b;
    item.v2 = c;
    item.v3 = d;
    if (op != OP_UNUSED) work_items++;
    push_cmd(item);
  endtask

  // One well-formed run: reload the matrix (usually whole, sometimes in part),
  // usually load a fresh initial state, then step a while.
  task automatic run_sequence();
    bit          wide;
    int unsigned nrows;
    int unsigned nsteps;
    logic [ssmr_pkg::ROW_W-1:0] r;
    wide = ($urandom_range(0, 3) == 0);
    nrows = ($urandom_range(0, 2) == 0) ? $urandom_range(0, ACTIVE) : ACTIVE;
    for (int k = 0; k < nrows; k++) begin
      // A full reload goes in row order; a partial one hits random rows.
      r = ssmr_pkg::ROW_W'((nrows == ACTIVE) ? k : int'($urandom_range(0, LANES - 1)));
      // Keep row sums at or below one unless this run is meant to blow up.
      if (wide)
        send_cmd(ssmr_pkg::OP_LOAD_ROW, r, any_val(), any_val(), any_val(), any_val());
      else
        send_cmd(ssmr_pkg::OP_LOAD_ROW, r, near_val(QUARTER), near_val(QUARTER),
                 near_val(QUARTER), near_val(QUARTER));
    end
    if ($urandom_range(0, 4) != 0) begin
      if ($urandom_range(0, 1))
        send_cmd(ssmr_pkg::OP_LOAD_STATE, ssmr_pkg::ROW_W'($urandom_range(0, 3)),
                 any_val(), any_val(), any_val(), any_val());
      else
        send_cmd(ssmr_pkg::OP_LOAD_STATE, ssmr_pkg::ROW_W'($urandom_range(0, 3)),
                 near_val(1 << 20), near_val(1 << 20), near_val(1 << 20),
                 near_val(1 << 20));
    end
    nsteps = $urandom_range(1, 20);
    for (int k = 0; k < nsteps; k++) begin
      if ($urandom_range(0, 5) == 0)
        send_cmd(ssmr_pkg::OP_STEP, ssmr_pkg::ROW_W'($urandom_range(0, 3)),
                 any_val(), any_val(), any_val(), any_val());
      else
        send_cmd(ssmr_pkg::OP_STEP, ssmr_pkg::ROW_W'($urandom_range(0, 3)),
                 near_val(1 << 18), near_val(1 << 18), near_val(1 << 18),
                 near_val(1 << 18));
    end
  endtask

  // Noise: any op, any row, any values, including the dropped op code.
  task automatic run_noise();
    int unsigned n;
    n = $urandom_range(1, 8);
    for (int k = 0; k < n; k++)
      send_cmd(ssmr_pkg::OP_W'($urandom_range(0, 3)), ssmr_pkg::ROW_W'($urandom_range(0, 3)),
               any_val(), any_val(), any_val(), any_val());
  endtask

  initial begin
    // Hold a known value on reset and the cmd inputs before the first edge.
    rst <= 1'b1;
    cmd_ch.valid <= 1'b0;
    cmd_ch.payload <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Load every row before the first step, since unloaded
    // coefficients are undefined. Use the corners of the range in A.
    send_cmd(ssmr_pkg::OP_LOAD_ROW, 2'd0, ssmr_pkg::VAL_MAX, ssmr_pkg::VAL_MIN, '0,
             val_t'(-1));
    send_cmd(ssmr_pkg::OP_LOAD_ROW, 2'd1, val_t'(-1), val_t'(1), ssmr_pkg::VAL_MAX,
             ssmr_pkg::VAL_MIN);
    send_cmd(ssmr_pkg::OP_LOAD_ROW, 2'd2, '0, '0, ONE, '0);
    send_cmd(ssmr_pkg::OP_LOAD_ROW, 2'd3, HALF, -HALF, QUARTER, -ONE);
    // Step from the all-zero reset state: the new state is the input itself.
    send_cmd(ssmr_pkg::OP_STEP, 2'd0, ssmr_pkg::VAL_MAX, ssmr_pkg::VAL_MIN, '0,
             val_t'(-1));
    // Corner coefficients times corner state: clamp both ways; the -1 entries
    // floor tiny products to -1 instead of zero.
    send_cmd(ssmr_pkg::OP_STEP, 2'd3, '0, '0, '0, '0);
    send_cmd(ssmr_pkg::OP_STEP, 2'd1, val_t'(1), val_t'(-1), ONE, -ONE);
    send_cmd(ssmr_pkg::OP_LOAD_STATE, 2'd2, ssmr_pkg::VAL_MAX, ssmr_pkg::VAL_MAX,
             ssmr_pkg::VAL_MAX, ssmr_pkg::VAL_MAX);
    send_cmd(ssmr_pkg::OP_STEP, 2'd2, ssmr_pkg::VAL_MAX, ssmr_pkg::VAL_MAX,
             ssmr_pkg::VAL_MAX, ssmr_pkg::VAL_MAX);
    send_cmd(ssmr_pkg::OP_LOAD_STATE, 2'd1, ssmr_pkg::VAL_MIN, ssmr_pkg::VAL_MIN,
             ssmr_pkg::VAL_MIN, ssmr_pkg::VAL_MIN);
    send_cmd(ssmr_pkg::OP_STEP, 2'd3, ssmr_pkg::VAL_MIN, ssmr_pkg::VAL_MIN,
             ssmr_pkg::VAL_MIN, ssmr_pkg::VAL_MIN);
    // Dropped op code: must not touch A or the state, and gives no result.
    send_cmd(OP_UNUSED, 2'd3, ssmr_pkg::VAL_MAX, ssmr_pkg::VAL_MIN, val_t'(-1), val_t'(1));
    // Half times identity: the state decays, odd negatives round down.
    send_cmd(ssmr_pkg::OP_LOAD_ROW, 2'd0, HALF, '0, '0, '0);
    send_cmd(ssmr_pkg::OP_LOAD_ROW, 2'd1, '0, HALF, '0, '0);
    send_cmd(ssmr_pkg::OP_LOAD_ROW, 2'd2, '0, '0, HALF, '0);
    send_cmd(ssmr_pkg::OP_LOAD_ROW, 2'd3, '0, '0, '0, HALF);
    send_cmd(ssmr_pkg::OP_LOAD_STATE, 2'd0, ONE, -ONE, val_t'(3), val_t'(-3));
    send_cmd(ssmr_pkg::OP_STEP, 2'd0, '0, '0, '0, '0);
    send_cmd(ssmr_pkg::OP_STEP, 2'd1, val_t'(-1), val_t'(1), val_t'(-1), val_t'(1));
    send_cmd(OP_UNUSED, 2'd0, '0, '0, '0, '0);
    send_cmd(ssmr_pkg::OP_STEP, 2'd2, -ONE, ONE, '0, val_t'(-1));

    // Random part: mostly well-formed runs, the rest noise.
    while (work_items < WORK_ITEMS) begin
      if ($urandom_range(0, 9) < 7) run_sequence();
      else run_noise();
    end
    cmd_ch.valid <= 1'b0;

    // Drain: wait for every outstanding step, then watch for strays.
    while (tracker.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (tracker.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: a correct run takes well under a tenth of this.
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
+incdir+design
design/ssmr_pkg.sv
design/ssmr_stream_if.sv
design/ssmr_coef_bank.sv
design/ssmr_mac_row.sv
design/state_space_matrix_recurrence.sv
design/ssmr_checker.sv
sim/state_space_matrix_recurrence_test.sv
